@@ rtl/fpr_pkg.sv @@
`timescale 1ns / 1ps

package fpr_pkg;

  // Build-time sizing
  localparam int MAX_FRAMES = 8;
  localparam int PAGE_BITS  = 16;

  // Fixed field widths
  localparam int PAGE_W   = 16;
  localparam int CFG_W    = 4;
  localparam int SLOT_W   = 3;
  localparam int FAULT_W  = 32;

  // Derived widths
  localparam int IDX_W     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W     = $clog2(MAX_FRAMES + 1);
  localparam int CLAMP_W   = (CFG_W > CNT_W) ? CFG_W : CNT_W;
  localparam int SLOT_EXT_W = (IDX_W > SLOT_W) ? IDX_W : SLOT_W;

  // Stream payload widths, padded to bytes
  localparam int S_TDATA_W = ((PAGE_W + 7) / 8) * 8;
  localparam int M_DATA_BITS = SLOT_W + FAULT_W;
  localparam int M_TDATA_W = ((M_DATA_BITS + 7) / 8) * 8;

  // Frame count after reset, clamped to what is built
  localparam int FRAMES_RESET_RAW = 8;
  localparam int FRAMES_RESET =
    (FRAMES_RESET_RAW > MAX_FRAMES) ? MAX_FRAMES : FRAMES_RESET_RAW;

  // Per-cell control from the sequencing logic
  typedef struct packed {
    logic cmp_en;  // frame is filled and within the active count
    logic wr_en;   // load the incoming page into this frame
  } cell_ctrl_t;

  // One result item
  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  frame_slot;
    logic [FAULT_W-1:0] fault_count;
    logic               last_out;
  } result_t;

endpackage

@@ rtl/fpr_cell.sv @@
`timescale 1ns / 1ps

// One frame: holds a page, compares it against the reference and passes
// the hit-so-far flag on to the next frame in the row.
module fpr_cell (
  input  logic                          clk,
  input  logic [fpr_pkg::PAGE_BITS-1:0] page,
  input  fpr_pkg::cell_ctrl_t           ctrl,
  input  logic                          hit_in,
  output logic                          hit_out,
  output logic                          first_hit
);
  import fpr_pkg::*;

  logic [PAGE_BITS-1:0] frame_page;
  logic                 match;

  // Stored page, loaded on a fault that picks this frame
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      frame_page <= page;
    end
  end

  // Compare and priority chain: the lowest matching frame wins
  assign match     = ctrl.cmp_en && (frame_page == page);
  assign first_hit = match && !hit_in;
  assign hit_out   = hit_in || match;

endmodule

@@ rtl/fpr_skid.sv @@
`timescale 1ns / 1ps

// Output register plus one skid entry, so the input side keeps moving
// while a result waits for the sink.
module fpr_skid (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  input  fpr_pkg::result_t in_data,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output fpr_pkg::result_t out_data
);
  import fpr_pkg::*;

  logic    sk_valid;
  result_t sk_data;
  logic    out_take;

  assign out_take = out_valid && out_ready;
  assign in_ready = !sk_valid;

  // Valid flags
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else if (in_valid) begin
      out_valid <= 1'b1;
      if (out_valid && !out_take) begin
        sk_valid <= 1'b1;
      end
    end else if (out_take) begin
      out_valid <= sk_valid;
      sk_valid  <= 1'b0;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_valid) begin
      if (!out_valid || out_take) begin
        out_data <= in_data;
      end else begin
        sk_data <= in_data;
      end
    end else if (out_take && sk_valid) begin
      out_data <= sk_data;
    end
  end

endmodule

@@ rtl/fifo_page_replacement.sv @@
`timescale 1ns / 1ps

// Channel  | direction | transfer when             | payload
// s_*      | in        | s_tvalid & s_tready       | tdata: page_number; tlast: last_reference
// m_*      | out       | m_tvalid & m_tready       | tdata: frame_slot, fault_count; tuser: hit;
//          |           |                           | tlast: last_out
// cfg_*    | in        | cfg_valid & cfg_ready     | cfg_data: frames_in_use
//
// One reference per clock while s_tready is high: the compare across the frame
// row, the fault count and the pointer update all settle in the transfer cycle;
// the result is registered on its way to m_*. Synchronous reset clears the sequence
// state and sets the frame count to 8; stored pages need no clearing.
// A stalled sink holds one result in the output register and one in the
// skid entry; s_tready drops only when both are occupied.
module fifo_page_replacement (
  input  logic                          clk,
  input  logic                          rst,
  // s_tdata: [15:0] page_number
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [fpr_pkg::S_TDATA_W-1:0] s_tdata,
  input  logic                          s_tlast,
  // m_tdata: [2:0] frame_slot, [34:3] fault_count, rest zero
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [fpr_pkg::M_TDATA_W-1:0] m_tdata,
  // m_tuser: [0] hit
  output logic                          m_tuser,
  output logic                          m_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [fpr_pkg::CFG_W-1:0]     cfg_data
);
  import fpr_pkg::*;

  logic                  accept;
  logic [PAGE_BITS-1:0]  page;
  logic [CNT_W-1:0]      frames;
  logic [CNT_W-1:0]      frames_next;
  logic [CLAMP_W-1:0]    cfg_ext;
  logic [CNT_W-1:0]      filled_frames;
  logic [IDX_W-1:0]      victim_pointer;
  logic [FAULT_W-1:0]    fault_counter;
  logic [CNT_W-1:0]      limit;
  logic [IDX_W-1:0]      victim_use;
  logic [CNT_W-1:0]      victim_inc;
  logic                  not_full;
  logic [IDX_W-1:0]      miss_slot;
  logic [IDX_W-1:0]      hit_slot;
  logic [IDX_W-1:0]      slot;
  logic [SLOT_EXT_W-1:0] slot_ext;
  logic [FAULT_W-1:0]    fault_next;
  logic                  found;
  logic [MAX_FRAMES:0]   hit_chain;
  logic [MAX_FRAMES-1:0] first_hit;
  cell_ctrl_t            cell_ctrl [MAX_FRAMES];
  result_t               res_in;
  result_t               res_out;

  assign accept    = s_tvalid && s_tready;
  assign page      = s_tdata[PAGE_BITS-1:0];
  assign cfg_ready = 1'b1;

  // Frame count register, clamped to 1..MAX_FRAMES on write
  always_comb begin
    cfg_ext = CLAMP_W'(cfg_data);
    if (cfg_ext == '0) begin
      frames_next = CNT_W'(1);
    end else if (cfg_ext > CLAMP_W'(MAX_FRAMES)) begin
      frames_next = CNT_W'(MAX_FRAMES);
    end else begin
      frames_next = CNT_W'(cfg_ext);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      frames <= CNT_W'(FRAMES_RESET);
    end else if (cfg_valid && cfg_ready) begin
      frames <= frames_next;
    end
  end

  // Active compare range and fault placement
  assign limit      = (filled_frames < frames) ? filled_frames : frames;
  assign not_full   = filled_frames < frames;
  assign victim_use = (CNT_W'(victim_pointer) >= frames) ? '0 : victim_pointer;
  assign victim_inc = CNT_W'(victim_use) + CNT_W'(1);
  assign miss_slot  = not_full ? IDX_W'(filled_frames) : victim_use;

  // Row of frame cells
  assign hit_chain[0] = 1'b0;
  for (genvar i = 0; i < MAX_FRAMES; i++) begin : g_cell
    assign cell_ctrl[i].cmp_en = CNT_W'(i) < limit;
    assign cell_ctrl[i].wr_en  = accept && !found && (miss_slot == IDX_W'(i));

    fpr_cell u_cell (
      .clk       (clk),
      .page      (page),
      .ctrl      (cell_ctrl[i]),
      .hit_in    (hit_chain[i]),
      .hit_out   (hit_chain[i+1]),
      .first_hit (first_hit[i])
    );
  end
  assign found = hit_chain[MAX_FRAMES];

  // Encode the one-hot first match
  always_comb begin
    hit_slot = '0;
    for (int i = 0; i < MAX_FRAMES; i++) begin
      if (first_hit[i]) begin
        hit_slot = hit_slot | IDX_W'(i);
      end
    end
  end

  assign slot       = found ? hit_slot : miss_slot;
  assign slot_ext   = SLOT_EXT_W'(slot);
  assign fault_next = (fault_counter == '1) ? fault_counter : fault_counter + FAULT_W'(1);

  // Sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      filled_frames  <= '0;
      victim_pointer <= '0;
      fault_counter  <= '0;
    end else if (accept) begin
      if (s_tlast) begin
        filled_frames  <= '0;
        victim_pointer <= '0;
        fault_counter  <= '0;
      end else if (!found) begin
        fault_counter <= fault_next;
        if (not_full) begin
          filled_frames <= filled_frames + CNT_W'(1);
        end else begin
          victim_pointer <= (victim_inc >= frames) ? '0 : IDX_W'(victim_inc);
        end
      end
    end
  end

  // Result toward the output buffer
  assign res_in.hit         = found;
  assign res_in.frame_slot  = slot_ext[SLOT_W-1:0];
  assign res_in.fault_count = found ? fault_counter : fault_next;
  assign res_in.last_out    = s_tlast;

  fpr_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_data   (res_in),
    .in_ready  (s_tready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (res_out)
  );

  assign m_tdata = M_TDATA_W'({res_out.fault_count, res_out.frame_slot});
  assign m_tuser = res_out.hit;
  assign m_tlast = res_out.last_out;

endmodule

@@ rtl/fpr_checker.sv @@
`timescale 1ns / 1ps

// Port-level checks on the page replacement block
module fpr_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          s_tvalid,
  input logic                          s_tready,
  input logic                          m_tvalid,
  input logic                          m_tready,
  input logic [fpr_pkg::M_TDATA_W-1:0] m_tdata,
  input logic                          m_tuser,
  input logic                          m_tlast
);
  import fpr_pkg::*;

  // Output is empty right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("result valid after reset");

  // Input stalls only when a result is waiting at the output
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> m_tvalid)
    else $error("input stalled with empty output");

  // Every sequence starts with a fault, so every result counts one or more
  a_fault_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[SLOT_W +: FAULT_W] != '0)
    else $error("result with zero fault count");

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("result changed while stalled");

endmodule

bind fifo_page_replacement fpr_checker u_fpr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
